FILE: hw/rtl/lpfp_pkg.sv
// package for the length-prefixed frame parser
// holds the shared types, codes and reset constants; no dependencies
package lpfp_pkg;

    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [15:0] CHANNEL_LIMIT_RESET = 16'd256;
    localparam logic [31:0] PAYLOAD_LIMIT_RESET = 32'd1048576;

    // configuration register indexes
    localparam logic REG_CHANNEL_LIMIT = 1'b0;
    localparam logic REG_PAYLOAD_LIMIT = 1'b1;

    // byte kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_CHANNEL = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // status codes
    localparam logic [1:0] ST_MORE     = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;

    // error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_CHANNEL_LEN = 2'd1;
    localparam logic [1:0] ERR_PAYLOAD_LEN = 2'd2;
    localparam logic [1:0] ERR_LOCKED      = 2'd3;

    typedef enum logic [2:0] {
        PH_CH_LEN  = 3'd0,
        PH_CH_DATA = 3'd1,
        PH_PL_LEN  = 3'd2,
        PH_PL_DATA = 3'd3,
        PH_LOCKED  = 3'd4
    } phase_t;

    typedef struct packed {
        logic       restart;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [15:0] channel_limit;
        logic [31:0] payload_limit;
    } cfg_t;

    typedef struct packed {
        logic [31:0] payload_length;
        logic [15:0] channel_length;
        logic [1:0]  error_kind;
        logic [1:0]  status;
        logic [1:0]  byte_kind;
        logic [7:0]  out_byte;
    } result_t;

endpackage

FILE: hw/rtl/length_prefixed_frame_parser.sv
// top level of the length-prefixed frame parser
// ties the input stage, the two-entry queue and the parser core; uses lpfp_pkg
//
//  channel | direction | beat contents (lowest bit first)
//  s_      | in        | tdata: in_byte; tuser: restart
//  m_      | out       | tdata: out_byte, status, error_kind, channel_length,
//          |           |        payload_length; tuser: byte_kind
//  cfg_    | in        | register write: 0 channel length limit, 1 payload limit
//
// one byte per cycle sustained while m_tready stays high; each beat passes from s_ to m_
// through the input register, the queue entry and the result register
// the parser core updates all frame state as it takes each byte
// aresetn clears the parse state and restores both limits to their defaults
// the queue absorbs m_tready stalls so s_tready only drops once it is full
module length_prefixed_frame_parser #(
    parameter int unsigned CHANNEL_LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte, status, error_kind, channel_length, payload_length, zero fill
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,   // byte_kind
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata
);

    lpfp_pkg::cfg_t    cfg_reg, cfg_next;
    logic              f_valid;
    lpfp_pkg::item_t   f_item;
    logic              f_ready;
    logic              q_valid;
    lpfp_pkg::item_t   q_item;
    logic              q_pop;
    lpfp_pkg::result_t result;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                lpfp_pkg::REG_CHANNEL_LIMIT: cfg_next.channel_limit = cfg_wdata[15:0];
                lpfp_pkg::REG_PAYLOAD_LIMIT: cfg_next.payload_limit = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_limit <= lpfp_pkg::CHANNEL_LIMIT_RESET;
            cfg_reg.payload_limit <= lpfp_pkg::PAYLOAD_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lpfp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .f_valid  (f_valid),
        .f_item   (f_item),
        .f_ready  (f_ready)
    );

    lpfp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    lpfp_back #(
        .CHANNEL_LENGTH_BITS (CHANNEL_LENGTH_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    assign m_tdata = {4'd0, result.payload_length, result.channel_length,
                      result.error_kind, result.status, result.out_byte};
    assign m_tuser = result.byte_kind;

    // an error code appears exactly on error results
    a_err_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((result.status == lpfp_pkg::ST_ERROR)
                      == (result.error_kind != lpfp_pkg::ERR_NONE)))
        else $error("error_kind and status disagree");

    // completion on a header byte only for an empty payload
    a_empty_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.status == lpfp_pkg::ST_COMPLETE
                  && result.byte_kind == lpfp_pkg::KIND_HEADER)
        |-> (result.payload_length == 32'd0))
        else $error("header completion with non-empty payload");

    // name and payload bytes never carry an error
    a_data_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.byte_kind != lpfp_pkg::KIND_HEADER)
        |-> (result.status != lpfp_pkg::ST_ERROR))
        else $error("data byte flagged as error");

    // a complete frame never has a zero channel length
    a_complete_has_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.status == lpfp_pkg::ST_COMPLETE)
        |-> (result.channel_length != 16'd0 || CHANNEL_LENGTH_BITS > 16))
        else $error("complete frame without channel length");

endmodule

FILE: hw/rtl/lpfp_front.sv
// input stage of the frame parser: registers each accepted beat
// depends on lpfp_pkg for the item type
module lpfp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    output logic                f_valid,
    output lpfp_pkg::item_t     f_item,
    input  logic                f_ready
);

    logic            valid_reg;
    logic            valid_next;
    lpfp_pkg::item_t item_reg;
    lpfp_pkg::item_t item_next;

    assign s_tready = !valid_reg || f_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_tready) begin
            valid_next        = s_tvalid;
            item_next.data    = s_tdata;
            item_next.restart = s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

FILE: hw/rtl/lpfp_queue.sv
// two-entry queue between the input stage and the parser
// depends on lpfp_pkg for the item type and depth
module lpfp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  lpfp_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop,
    output lpfp_pkg::item_t pop_item
);

    localparam int unsigned PTR_W = $clog2(lpfp_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(lpfp_pkg::QUEUE_DEPTH + 1);

    lpfp_pkg::item_t entry_reg [lpfp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(lpfp_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lpfp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lpfp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/lpfp_back.sv
// parser core: frame state machine, length assembly and the result register
// depends on lpfp_pkg for phases, codes, item, config and result types
module lpfp_back #(
    parameter int unsigned CHANNEL_LENGTH_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lpfp_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  lpfp_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output lpfp_pkg::result_t m_result
);

    localparam int unsigned CLB = CHANNEL_LENGTH_BITS;

    lpfp_pkg::phase_t  phase_reg, phase_next, phase_eff;
    logic [1:0]        cnt_reg, cnt_next, cnt_eff;
    logic [31:0]       asm_reg, asm_next, asm_eff;
    logic [CLB-1:0]    chlen_reg, chlen_next, chlen_eff;
    logic [CLB-1:0]    chpos_reg, chpos_next, chpos_eff;
    logic [31:0]       pllen_reg, pllen_next, pllen_eff;
    logic [31:0]       plpos_reg, plpos_next, plpos_eff;

    logic              out_valid_reg, out_valid_next;
    lpfp_pkg::result_t out_reg, out_next;

    logic [31:0]       asm_base;
    logic [31:0]       asm_full;
    logic              last_hdr;
    logic              ch_bad;
    logic              pl_bad;
    logic [CLB-1:0]    chpos_inc;
    logic [31:0]       plpos_inc;

    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    // restart clears parse state ahead of the byte
    always_comb begin
        if (q_item.restart) begin
            phase_eff = lpfp_pkg::PH_CH_LEN;
            cnt_eff   = '0;
            asm_eff   = '0;
            chlen_eff = '0;
            chpos_eff = '0;
            pllen_eff = '0;
            plpos_eff = '0;
        end else begin
            phase_eff = phase_reg;
            cnt_eff   = cnt_reg;
            asm_eff   = asm_reg;
            chlen_eff = chlen_reg;
            chpos_eff = chpos_reg;
            pllen_eff = pllen_reg;
            plpos_eff = plpos_reg;
        end
    end

    // header byte assembly, little-endian
    assign asm_base = (phase_eff == lpfp_pkg::PH_CH_LEN && cnt_eff == 2'd0) ? 32'd0 : asm_eff;
    assign asm_full = asm_base | ({24'd0, q_item.data} << {cnt_eff, 3'b000});
    assign last_hdr = cnt_eff == 2'(lpfp_pkg::HEADER_BYTES - 1);

    assign ch_bad = (asm_full == 32'd0)
                 || (asm_full >= {16'd0, cfg.channel_limit})
                 || ((33'(asm_full) >> CLB) != 33'd0);
    assign pl_bad = asm_full > cfg.payload_limit;

    assign chpos_inc = chpos_eff + CLB'(1);
    assign plpos_inc = plpos_eff + 32'd1;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (q_pop) begin
            case (phase_eff)
                lpfp_pkg::PH_CH_LEN: begin
                    if (last_hdr) begin
                        phase_next = ch_bad ? lpfp_pkg::PH_LOCKED : lpfp_pkg::PH_CH_DATA;
                    end else begin
                        phase_next = lpfp_pkg::PH_CH_LEN;
                    end
                end
                lpfp_pkg::PH_CH_DATA: begin
                    phase_next = (chpos_inc == chlen_eff) ? lpfp_pkg::PH_PL_LEN
                                                          : lpfp_pkg::PH_CH_DATA;
                end
                lpfp_pkg::PH_PL_LEN: begin
                    if (!last_hdr) begin
                        phase_next = lpfp_pkg::PH_PL_LEN;
                    end else if (pl_bad) begin
                        phase_next = lpfp_pkg::PH_LOCKED;
                    end else if (asm_full == 32'd0) begin
                        phase_next = lpfp_pkg::PH_CH_LEN;
                    end else begin
                        phase_next = lpfp_pkg::PH_PL_DATA;
                    end
                end
                lpfp_pkg::PH_PL_DATA: begin
                    phase_next = (plpos_inc == pllen_eff) ? lpfp_pkg::PH_CH_LEN
                                                          : lpfp_pkg::PH_PL_DATA;
                end
                default: phase_next = lpfp_pkg::PH_LOCKED;
            endcase
        end
    end

    // datapath state and result
    always_comb begin
        cnt_next   = cnt_reg;
        asm_next   = asm_reg;
        chlen_next = chlen_reg;
        chpos_next = chpos_reg;
        pllen_next = pllen_reg;
        plpos_next = plpos_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        if (q_pop) begin
            cnt_next   = cnt_eff;
            asm_next   = asm_eff;
            chlen_next = chlen_eff;
            chpos_next = chpos_eff;
            pllen_next = pllen_eff;
            plpos_next = plpos_eff;
            out_valid_next      = 1'b1;
            out_next.out_byte   = q_item.data;
            out_next.byte_kind  = lpfp_pkg::KIND_HEADER;
            out_next.status     = lpfp_pkg::ST_MORE;
            out_next.error_kind = lpfp_pkg::ERR_NONE;

            case (phase_eff)
                lpfp_pkg::PH_CH_LEN: begin
                    if (cnt_eff == 2'd0) begin
                        chlen_next = '0;
                        pllen_next = '0;
                    end
                    if (last_hdr) begin
                        asm_next   = '0;
                        cnt_next   = '0;
                        chlen_next = asm_full[CLB-1:0];
                        if (ch_bad) begin
                            out_next.status     = lpfp_pkg::ST_ERROR;
                            out_next.error_kind = lpfp_pkg::ERR_CHANNEL_LEN;
                        end else begin
                            chpos_next = '0;
                        end
                    end else begin
                        asm_next = asm_full;
                        cnt_next = cnt_eff + 2'd1;
                    end
                end
                lpfp_pkg::PH_CH_DATA: begin
                    out_next.byte_kind = lpfp_pkg::KIND_CHANNEL;
                    chpos_next = chpos_inc;
                    if (chpos_inc == chlen_eff) begin
                        cnt_next = '0;
                        asm_next = '0;
                    end
                end
                lpfp_pkg::PH_PL_LEN: begin
                    if (last_hdr) begin
                        asm_next   = '0;
                        cnt_next   = '0;
                        pllen_next = asm_full;
                        if (pl_bad) begin
                            out_next.status     = lpfp_pkg::ST_ERROR;
                            out_next.error_kind = lpfp_pkg::ERR_PAYLOAD_LEN;
                        end else begin
                            plpos_next = '0;
                            if (asm_full == 32'd0) begin
                                out_next.status = lpfp_pkg::ST_COMPLETE;
                                chpos_next      = '0;
                            end
                        end
                    end else begin
                        asm_next = asm_full;
                        cnt_next = cnt_eff + 2'd1;
                    end
                end
                lpfp_pkg::PH_PL_DATA: begin
                    out_next.byte_kind = lpfp_pkg::KIND_PAYLOAD;
                    plpos_next = plpos_inc;
                    if (plpos_inc == pllen_eff) begin
                        out_next.status = lpfp_pkg::ST_COMPLETE;
                        chpos_next = '0;
                        cnt_next   = '0;
                        asm_next   = '0;
                    end
                end
                default: begin
                    out_next.status     = lpfp_pkg::ST_ERROR;
                    out_next.error_kind = lpfp_pkg::ERR_LOCKED;
                end
            endcase

            out_next.channel_length = 16'(32'(chlen_next));
            out_next.payload_length = pllen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= lpfp_pkg::PH_CH_LEN;
            cnt_reg       <= '0;
            asm_reg       <= '0;
            chlen_reg     <= '0;
            chpos_reg     <= '0;
            pllen_reg     <= '0;
            plpos_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            asm_reg       <= asm_next;
            chlen_reg     <= chlen_next;
            chpos_reg     <= chpos_next;
            pllen_reg     <= pllen_next;
            plpos_reg     <= plpos_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

FILE: tb/sv/length_prefixed_frame_parser_tb.sv
// self-checking testbench for the length-prefixed frame parser
// drives byte beats through the stream ports and checks every result beat
// against a scoreboard with its own frame model; depends on lpfp_pkg and the rtl

class frame_scoreboard;
    logic [31:0] chan_mask;
    logic [15:0] chan_limit;
    logic [31:0] pay_limit;

    lpfp_pkg::phase_t phase;
    logic [1:0]  hdr_count;
    logic [31:0] assembly;
    logic [31:0] chan_len;
    logic [31:0] chan_pos;
    logic [31:0] pay_len;
    logic [31:0] pay_pos;

    lpfp_pkg::result_t expected_results[$];
    int          failures;

    function new(int unsigned chan_bits);
        chan_mask  = 32'((64'd1 << chan_bits) - 64'd1);
        chan_limit = lpfp_pkg::CHANNEL_LIMIT_RESET;
        pay_limit  = lpfp_pkg::PAYLOAD_LIMIT_RESET;
        failures   = 0;
        clear_frame();
    endfunction

    function void clear_frame();
        phase     = lpfp_pkg::PH_CH_LEN;
        hdr_count = '0;
        assembly  = '0;
        chan_len  = '0;
        chan_pos  = '0;
        pay_len   = '0;
        pay_pos   = '0;
    endfunction

    function void set_limit(logic addr, logic [31:0] value);
        if (addr == lpfp_pkg::REG_CHANNEL_LIMIT) begin
            chan_limit = value[15:0];
        end else begin
            pay_limit = value;
        end
    endfunction

    function int pending();
        return expected_results.size();
    endfunction

    // little-endian assembly; returns 1 once the fourth byte is in
    function bit length_done(logic [7:0] b, output logic [31:0] value);
        assembly = assembly | (32'(b) << (8 * hdr_count));
        value = assembly;
        if (hdr_count == 2'd3) begin
            assembly  = '0;
            hdr_count = '0;
            return 1'b1;
        end
        hdr_count = hdr_count + 2'd1;
        return 1'b0;
    endfunction

    function void note_input(lpfp_pkg::item_t beat);
        lpfp_pkg::result_t r;
        logic [31:0]       v;
        r            = '0;
        r.out_byte   = beat.data;
        r.byte_kind  = lpfp_pkg::KIND_HEADER;
        r.status     = lpfp_pkg::ST_MORE;
        r.error_kind = lpfp_pkg::ERR_NONE;
        if (beat.restart) begin
            clear_frame();
        end
        case (phase)
            lpfp_pkg::PH_CH_LEN: begin
                // a new frame starts with both lengths unknown
                if (hdr_count == 2'd0) begin
                    chan_len = '0;
                    pay_len  = '0;
                    assembly = '0;
                end
                if (length_done(beat.data, v)) begin
                    if (v == 0 || v >= 32'(chan_limit) || v > chan_mask) begin
                        chan_len     = v & chan_mask;
                        phase        = lpfp_pkg::PH_LOCKED;
                        r.status     = lpfp_pkg::ST_ERROR;
                        r.error_kind = lpfp_pkg::ERR_CHANNEL_LEN;
                    end else begin
                        chan_len = v;
                        chan_pos = '0;
                        phase    = lpfp_pkg::PH_CH_DATA;
                    end
                end
            end
            lpfp_pkg::PH_CH_DATA: begin
                r.byte_kind = lpfp_pkg::KIND_CHANNEL;
                chan_pos    = (chan_pos + 1) & chan_mask;
                if (chan_pos == chan_len) begin
                    hdr_count = '0;
                    assembly  = '0;
                    phase     = lpfp_pkg::PH_PL_LEN;
                end
            end
            lpfp_pkg::PH_PL_LEN: begin
                if (length_done(beat.data, v)) begin
                    pay_len = v;
                    if (v > pay_limit) begin
                        phase        = lpfp_pkg::PH_LOCKED;
                        r.status     = lpfp_pkg::ST_ERROR;
                        r.error_kind = lpfp_pkg::ERR_PAYLOAD_LEN;
                    end else begin
                        pay_pos = '0;
                        if (v == 0) begin
                            r.status = lpfp_pkg::ST_COMPLETE;
                            chan_pos = '0;
                            phase    = lpfp_pkg::PH_CH_LEN;
                        end else begin
                            phase = lpfp_pkg::PH_PL_DATA;
                        end
                    end
                end
            end
            lpfp_pkg::PH_PL_DATA: begin
                r.byte_kind = lpfp_pkg::KIND_PAYLOAD;
                pay_pos     = pay_pos + 1;
                if (pay_pos == pay_len) begin
                    r.status  = lpfp_pkg::ST_COMPLETE;
                    chan_pos  = '0;
                    hdr_count = '0;
                    assembly  = '0;
                    phase     = lpfp_pkg::PH_CH_LEN;
                end
            end
            default: begin
                r.status     = lpfp_pkg::ST_ERROR;
                r.error_kind = lpfp_pkg::ERR_LOCKED;
            end
        endcase
        r.channel_length = chan_len[15:0];
        r.payload_length = pay_len;
        expected_results.push_back(r);
    endfunction

    task report(string msg);
        failures++;
        if (failures <= 20) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task check_result(lpfp_pkg::result_t got);
        lpfp_pkg::result_t want;
        if (expected_results.size() == 0) begin
            report($sformatf("result beat with byte %02h and nothing pending", got.out_byte));
            return;
        end
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte)
            report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.byte_kind !== want.byte_kind)
            report($sformatf("byte_kind %0d, want %0d", got.byte_kind, want.byte_kind));
        if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
        if (got.error_kind !== want.error_kind)
            report($sformatf("error_kind %0d, want %0d", got.error_kind, want.error_kind));
        if (got.channel_length !== want.channel_length)
            report($sformatf("channel_length %0d, want %0d",
                             got.channel_length, want.channel_length));
        if (got.payload_length !== want.payload_length)
            report($sformatf("payload_length %0d, want %0d",
                             got.payload_length, want.payload_length));
    endtask
endclass

module length_prefixed_frame_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CH_BITS     = 16;
    localparam int          CYCLE_LIMIT = 400000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = lpfp_pkg::REG_CHANNEL_LIMIT;
    logic [31:0] cfg_wdata = '0;

    frame_scoreboard sb = new(CH_BITS);

    logic [7:0] seq[$];
    int         burst_left   = 0;
    int         bytes_sent   = 0;
    int         cycle_count  = 0;
    bit         resync       = 1'b0;
    bit         hold_request = 1'b0;
    lpfp_pkg::result_t monitored;

    length_prefixed_frame_parser #(
        .CHANNEL_LENGTH_BITS(CH_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result beats, unpacked from the lowest bit up
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            monitored                = '0;
            monitored.out_byte       = m_tdata[7:0];
            monitored.status         = m_tdata[9:8];
            monitored.error_kind     = m_tdata[11:10];
            monitored.channel_length = m_tdata[27:12];
            monitored.payload_length = m_tdata[59:28];
            monitored.byte_kind      = m_tuser;
            sb.check_result(monitored);
        end
    end

    // receiver: stall patterns that change at random intervals, plus one long hold-off
    initial begin
        int mode_left;
        int hold_left;
        int rx_mode;
        int tick;
        bit hold_done;
        mode_left = 0;
        hold_left = 0;
        rx_mode   = 0;
        tick      = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= (tick % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // one beat, with the sender's burst and gap pattern in front of it
    task automatic send_byte(input logic [7:0] b, input logic rst);
        int              gap;
        lpfp_pkg::item_t beat;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        beat.data    = b;
        beat.restart = rst;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= rst;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(beat);
        bytes_sent++;
    endtask

    task automatic add_word(input logic [31:0] v);
        for (int i = 0; i < lpfp_pkg::HEADER_BYTES; i++) begin
            seq.push_back(v[8*i +: 8]);
        end
    endtask

    task automatic add_random(input int n);
        repeat (n) seq.push_back(8'($urandom));
    endtask

    task automatic send_seq(input bit restart_first);
        foreach (seq[i]) begin
            send_byte(seq[i], restart_first && i == 0);
        end
        seq.delete();
    endtask

    // stop offering, let every pending result out and the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_limits(input logic [15:0] ch, input logic [31:0] pl);
        logic [31:0] ch_word;
        ch_word   = {16'($urandom), ch};
        cfg_wr_en <= 1'b1;
        cfg_addr  <= lpfp_pkg::REG_CHANNEL_LIMIT;
        cfg_wdata <= ch_word;
        @(posedge aclk);
        sb.set_limit(lpfp_pkg::REG_CHANNEL_LIMIT, ch_word);
        cfg_addr  <= lpfp_pkg::REG_PAYLOAD_LIMIT;
        cfg_wdata <= pl;
        @(posedge aclk);
        sb.set_limit(lpfp_pkg::REG_PAYLOAD_LIMIT, pl);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly well-formed frames with random content, some bad lengths,
    // truncated frames and noise; anything that breaks framing is followed by restart
    task automatic random_frame();
        int          pick;
        int          cl_max;
        int          pl_max;
        int          n;
        logic [31:0] cl;
        logic [31:0] pl;
        bit          first_rst;
        bit          fails;
        first_rst = resync || ($urandom_range(0, 15) == 0);
        resync    = 1'b0;
        pick      = $urandom_range(0, 19);
        cl_max    = (sb.chan_limit > 16'd9) ? 8 : int'(sb.chan_limit) - 1;
        pl_max    = (sb.pay_limit > 32'd10) ? 10 : int'(sb.pay_limit);
        cl        = (cl_max < 1) ? $urandom_range(1, 8) : $urandom_range(1, cl_max);
        pl        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, pl_max);
        fails     = (cl_max < 1);
        if (pick == 0) begin
            case ($urandom_range(0, 3))
                0: cl = 0;
                1: cl = 32'(sb.chan_limit);
                2: cl = 32'h0001_0000 | $urandom;
                default: cl = $urandom;
            endcase
            fails = 1'b1;
        end
        if (pick == 3) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
            first_rst = 1'b1;
        end
        add_word(cl);
        if (fails) begin
            add_random($urandom_range(0, 4));
            resync = 1'b1;
        end else begin
            add_random(cl);
            if (pick == 1 && sb.pay_limit != 32'hFFFF_FFFF) begin
                pl = ($urandom_range(0, 1) == 1) ? sb.pay_limit + 1
                                                 : $urandom_range(32'hFFFF_FFFF, sb.pay_limit + 1);
                add_word(pl);
                add_random($urandom_range(0, 4));
                resync = 1'b1;
            end else begin
                add_word(pl);
                add_random(pl);
            end
        end
        if (pick == 2) begin
            n = $urandom_range(1, seq.size());
            while (seq.size() > n) void'(seq.pop_back());
            resync = 1'b1;
        end
        send_seq(first_rst);
    endtask

    task automatic random_phase(input int n_bytes);
        int start;
        start  = bytes_sent;
        resync = 1'b1;
        while (bytes_sent - start < n_bytes) random_frame();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty payload: frame completes on the last length byte
        add_word(1);
        seq.push_back(8'h00);
        add_word(0);
        send_seq(1'b1);
        // next frame straight after, extreme byte values
        add_word(3);
        seq.push_back(8'hFF);
        seq.push_back(8'h00);
        seq.push_back(8'hA5);
        add_word(2);
        seq.push_back(8'hFF);
        seq.push_back(8'h00);
        send_seq(1'b0);
        // zero channel length, then locked beats
        add_word(0);
        seq.push_back(8'h5A);
        seq.push_back(8'hC3);
        send_seq(1'b0);
        // channel length at the limit
        add_word(32'd256);
        seq.push_back(8'h11);
        send_seq(1'b1);
        // channel length too wide for the counter
        add_word(32'hFFFF_FFFF);
        send_seq(1'b1);
        // payload length over the limit
        add_word(2);
        add_random(2);
        add_word(32'h0010_0001);
        seq.push_back(8'h77);
        send_seq(1'b1);
        // restart in the middle of the channel name
        add_word(2);
        seq.push_back(8'h01);
        send_seq(1'b1);
        add_word(1);
        seq.push_back(8'h42);
        add_word(1);
        seq.push_back(8'h99);
        send_seq(1'b1);
        // restart in the middle of a length header
        seq.push_back(8'h05);
        seq.push_back(8'h00);
        send_seq(1'b0);
        add_word(1);
        seq.push_back(8'h3C);
        add_word(0);
        send_seq(1'b1);
        settle();

        // a channel limit of zero rejects everything
        set_limits(16'd0, 32'd3);
        add_word(1);
        send_seq(1'b1);
        settle();

        // payload exactly at the limit, then one over
        set_limits(16'd2, 32'd3);
        add_word(1);
        seq.push_back(8'h80);
        add_word(3);
        add_random(3);
        add_word(1);
        seq.push_back(8'h01);
        add_word(4);
        send_seq(1'b1);
        add_word(2);
        send_seq(1'b1);
        settle();

        set_limits(lpfp_pkg::CHANNEL_LIMIT_RESET, lpfp_pkg::PAYLOAD_LIMIT_RESET);
        random_phase(105);
        settle();

        set_limits(16'hFFFF, 32'hFFFF_FFFF);
        hold_request = 1'b1;
        random_phase(105);
        settle();

        set_limits(16'd1, 32'd0);
        random_phase(100);
        settle();

        set_limits(16'($urandom_range(2, 16)), 32'($urandom_range(0, 12)));
        random_phase(105);
        settle();

        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
